### src/assert_macros.svh
// Assertion macros used by the checker file of the cover counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger
`define GRCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Trigger in one cycle, consequence in the following one
`define GRCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/grcc_pkg.sv
// Package for the grid rectangle cover counter: sizes, codes and item types.
package grcc_pkg;

    // Grid geometry and cell format
    localparam int GRID_SIDE = 256;
    localparam int COORD_W   = $clog2(GRID_SIDE);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W    = 12;
    localparam int COUNT_W   = CELL_W - 1;

    // Item field widths
    localparam int FIELD_W   = 8;
    localparam int OP_W      = 2;

    // Rectangle limit
    localparam int MAX_RECTS = 1024;
    localparam int RECT_W    = $clog2(MAX_RECTS + 1);

    // Configuration port
    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET      = SIZE_W'(GRID_SIDE);

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_ACCUM = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // Status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Rectangle kinds
    localparam logic KIND_HORIZONTAL = 1'b0;
    localparam logic KIND_VERTICAL   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               kind;
        logic [FIELD_W-1:0] x_lo;
        logic [FIELD_W-1:0] x_hi;
        logic [FIELD_W-1:0] y_lo;
        logic [FIELD_W-1:0] y_hi;
    } grcc_in_t;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] horizontal_count;
        logic [COUNT_W-1:0] vertical_count;
    } grcc_out_t;

endpackage

### src/grcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grcc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/grid_rectangle_cover_counter_top.sv
// Top level of the grid rectangle cover counter: sequencer around two grid RAMs.
//
// Two 256 x 256 grids of 12-bit cells count horizontal and vertical
// rectangles by the difference-array method. One item is taken at a time;
// req_ready is low while it is worked on, and every item gives one result,
// which waits in an output register. Each grid RAM has a single read port
// and a single write port: an add does four corner read-modify-writes, a
// clear zeroes one cell of both grids per cycle, an accumulate runs a row
// pass then a column pass, streaming one cell per cycle, and a rejected
// add or a repeated accumulate goes straight to its result. After reset
// the grids are zeroed by a clearing pass over all 65536 cells during
// which no item is taken; configuration writes are taken at all times.
module grid_rectangle_cover_counter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  grcc_pkg::grcc_in_t               req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output grcc_pkg::grcc_out_t              rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [grcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [grcc_pkg::SIZE_W-1:0]      cfg_data
);

    import grcc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_CLEAR   = 11'b000_0000_0010,
        S_ADD_RD  = 11'b000_0000_0100,
        S_ADD_WR  = 11'b000_0000_1000,
        S_ACC_ROW = 11'b000_0001_0000,
        S_ACC_MID = 11'b000_0010_0000,
        S_ACC_COL = 11'b000_0100_0000,
        S_ACC_END = 11'b000_1000_0000,
        S_RD_ISS  = 11'b001_0000_0000,
        S_RD_CAP  = 11'b010_0000_0000,
        S_FIN     = 11'b100_0000_0000
    } state_t;

    // Clamp a size register to 1..GRID_SIDE and return the last index
    function automatic logic [COORD_W-1:0] size_last(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] eff;
        if (v == '0)
        begin
            eff = SIZE_W'(1);
        end
        else if (v > SIZE_W'(GRID_SIDE))
        begin
            eff = SIZE_W'(GRID_SIDE);
        end
        else
        begin
            eff = v;
        end
        return COORD_W'(eff - SIZE_W'(1));
    endfunction

    // Negative cells read as zero
    function automatic logic [COUNT_W-1:0] cell_count(input logic [CELL_W-1:0] c);
        return c[CELL_W-1] ? '0 : c[COUNT_W-1:0];
    endfunction

    // Control state
    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   cols_reg, cols_next;
    logic [SIZE_W-1:0]   rows_reg, rows_next;
    logic [RECT_W-1:0]   rect_reg, rect_next;
    logic                acc_done_reg, acc_done_next;
    logic                clr_reply_reg, clr_reply_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [1:0]          corner_reg, corner_next;
    logic [COORD_W-1:0]  outer_reg, outer_next;
    logic [COORD_W-1:0]  inner_reg, inner_next;
    logic                pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Payload state
    grcc_in_t            item_reg, item_next;
    grcc_out_t           res_reg, res_next;
    grcc_out_t           rsp_reg, rsp_next;
    logic [COORD_W-1:0]  wlim_reg, wlim_next;
    logic [COORD_W-1:0]  hlim_reg, hlim_next;
    logic                pend_first_reg, pend_first_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [CELL_W-1:0]   run_h_reg, run_h_next;
    logic [CELL_W-1:0]   run_v_reg, run_v_next;

    // Grid RAM ports
    logic                we_h, we_v;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [CELL_W-1:0]   wdata_h, wdata_v;
    logic [CELL_W-1:0]   rdata_h, rdata_v;

    // Corner and walk helpers
    logic [FIELD_W:0]    xa, xb, ya, yb, cx, cy;
    logic                c_plus, c_in, r_in;
    logic [ADDR_W-1:0]   c_addr, r_addr, walk_addr;
    logic [CELL_W-1:0]   c_sum, sum_h, sum_v;
    logic [COORD_W-1:0]  ilim, olim;
    logic                walk_last;

    grcc_ram #(.WIDTH(CELL_W), .DEPTH(GRID_CELLS)) u_ram_h (
        .clk   (clk),
        .we    (we_h),
        .waddr (mem_waddr),
        .wdata (wdata_h),
        .raddr (mem_raddr),
        .rdata (rdata_h)
    );

    grcc_ram #(.WIDTH(CELL_W), .DEPTH(GRID_CELLS)) u_ram_v (
        .clk   (clk),
        .we    (we_v),
        .waddr (mem_waddr),
        .wdata (wdata_v),
        .raddr (mem_raddr),
        .rdata (rdata_v)
    );

    // Corner k of an add: bit 0 picks the far column, bit 1 the far row
    always_comb
    begin
        xa     = {1'b0, item_reg.x_lo};
        xb     = {1'b0, item_reg.x_hi} + (FIELD_W+1)'(item_reg.kind == KIND_VERTICAL);
        ya     = {1'b0, item_reg.y_lo};
        yb     = {1'b0, item_reg.y_hi} + (FIELD_W+1)'(item_reg.kind == KIND_HORIZONTAL);
        cx     = corner_reg[0] ? xb : xa;
        cy     = corner_reg[1] ? yb : ya;
        c_plus = (corner_reg[0] == corner_reg[1]);
        c_in   = (cx < (FIELD_W+1)'(GRID_SIDE)) && (cy < (FIELD_W+1)'(GRID_SIDE));
        c_addr = {cx[COORD_W-1:0], cy[COORD_W-1:0]};
        c_sum  = (item_reg.kind == KIND_VERTICAL) ? rdata_v : rdata_h;
        c_sum  = c_sum + (c_plus ? CELL_W'(1) : {CELL_W{1'b1}});
        r_in   = ({1'b0, item_reg.x_lo} < (FIELD_W+1)'(GRID_SIDE))
              && ({1'b0, item_reg.y_lo} < (FIELD_W+1)'(GRID_SIDE));
        r_addr = {item_reg.x_lo[COORD_W-1:0], item_reg.y_lo[COORD_W-1:0]};
    end

    // Prefix-sum walk: row pass runs y inside x, column pass x inside y
    always_comb
    begin
        if (state_reg == S_ACC_COL)
        begin
            ilim      = wlim_reg;
            olim      = hlim_reg;
            walk_addr = {inner_reg, outer_reg};
        end
        else
        begin
            ilim      = hlim_reg;
            olim      = wlim_reg;
            walk_addr = {outer_reg, inner_reg};
        end
        walk_last = (inner_reg == ilim) && (outer_reg == olim);
        sum_h     = pend_first_reg ? rdata_h : rdata_h + run_h_reg;
        sum_v     = pend_first_reg ? rdata_v : rdata_v + run_v_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        rect_next       = rect_reg;
        acc_done_next   = acc_done_reg;
        clr_reply_next  = clr_reply_reg;
        clr_addr_next   = clr_addr_reg;
        corner_next     = corner_reg;
        outer_next      = outer_reg;
        inner_next      = inner_reg;
        pend_next       = 1'b0;
        rsp_valid_next  = rsp_valid_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        wlim_next       = wlim_reg;
        hlim_next       = hlim_reg;
        pend_first_next = pend_first_reg;
        pend_addr_next  = pend_addr_reg;
        run_h_next      = run_h_reg;
        run_v_next      = run_v_reg;
        we_h            = 1'b0;
        we_v            = 1'b0;
        mem_waddr       = c_addr;
        mem_raddr       = c_addr;
        wdata_h         = c_sum;
        wdata_v         = c_sum;

        req_ready = (state_reg == S_IDLE);
        cfg_ready = 1'b1;

        // Size registers
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COLS_IN_USE: cols_next = cfg_data;
                CFG_ROWS_IN_USE: rows_next = cfg_data;
                default:         ;
            endcase
        end

        // Result taken downstream
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Write-back of the walk cell whose read was issued in the previous cycle
        if (pend_reg)
        begin
            run_h_next = sum_h;
            run_v_next = sum_v;
            if (!pend_first_reg)
            begin
                we_h      = 1'b1;
                we_v      = 1'b1;
                mem_waddr = pend_addr_reg;
                wdata_h   = sum_h;
                wdata_v   = sum_v;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    res_next  = '0;
                    case (req.op)
                        OP_CLEAR:
                        begin
                            rect_next      = '0;
                            acc_done_next  = 1'b0;
                            clr_addr_next  = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        OP_ADD:
                        begin
                            if (acc_done_reg || (rect_reg >= RECT_W'(MAX_RECTS)))
                            begin
                                res_next.status = STATUS_REJECT;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                rect_next   = rect_reg + RECT_W'(1);
                                corner_next = '0;
                                state_next  = S_ADD_RD;
                            end
                        end
                        OP_ACCUM:
                        begin
                            if (acc_done_reg)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                acc_done_next = 1'b1;
                                wlim_next     = size_last(cols_reg);
                                hlim_next     = size_last(rows_reg);
                                outer_next    = '0;
                                inner_next    = '0;
                                state_next    = S_ACC_ROW;
                            end
                        end
                        OP_READ:
                        begin
                            state_next = S_RD_ISS;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // One cell of both grids zeroed per cycle
            S_CLEAR:
            begin
                we_h          = 1'b1;
                we_v          = 1'b1;
                mem_waddr     = clr_addr_reg;
                wdata_h       = '0;
                wdata_v       = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = clr_reply_reg ? S_FIN : S_IDLE;
                end
            end

            S_ADD_RD:
            begin
                mem_raddr  = c_addr;
                state_next = S_ADD_WR;
            end

            // Corner past the edge is dropped
            S_ADD_WR:
            begin
                mem_waddr   = c_addr;
                we_h        = c_in && (item_reg.kind == KIND_HORIZONTAL);
                we_v        = c_in && (item_reg.kind == KIND_VERTICAL);
                corner_next = corner_reg + 2'd1;
                state_next  = (corner_reg == 2'd3) ? S_FIN : S_ADD_RD;
            end

            S_ACC_ROW, S_ACC_COL:
            begin
                mem_raddr       = walk_addr;
                pend_next       = 1'b1;
                pend_first_next = (inner_reg == '0);
                pend_addr_next  = walk_addr;
                if (inner_reg == ilim)
                begin
                    inner_next = '0;
                    outer_next = outer_reg + COORD_W'(1);
                end
                else
                begin
                    inner_next = inner_reg + COORD_W'(1);
                end
                if (walk_last)
                begin
                    state_next = (state_reg == S_ACC_ROW) ? S_ACC_MID : S_ACC_END;
                end
            end

            // Last row-pass write lands here, then the column pass starts
            S_ACC_MID:
            begin
                outer_next = '0;
                inner_next = '0;
                state_next = S_ACC_COL;
            end

            S_ACC_END:
            begin
                state_next = S_FIN;
            end

            S_RD_ISS:
            begin
                mem_raddr  = r_addr;
                state_next = S_RD_CAP;
            end

            S_RD_CAP:
            begin
                res_next.status           = STATUS_OK;
                res_next.horizontal_count = r_in ? cell_count(rdata_h) : '0;
                res_next.vertical_count   = r_in ? cell_count(rdata_v) : '0;
                state_next                = S_FIN;
            end

            // Hand the result to the output register once it is free
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cols_reg      <= SIZE_RESET;
            rows_reg      <= SIZE_RESET;
            rect_reg      <= '0;
            acc_done_reg  <= 1'b0;
            clr_reply_reg <= 1'b0;
            clr_addr_reg  <= '0;
            corner_reg    <= '0;
            outer_reg     <= '0;
            inner_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            rect_reg      <= rect_next;
            acc_done_reg  <= acc_done_next;
            clr_reply_reg <= clr_reply_next;
            clr_addr_reg  <= clr_addr_next;
            corner_reg    <= corner_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
        wlim_reg       <= wlim_next;
        hlim_reg       <= hlim_next;
        pend_first_reg <= pend_first_next;
        pend_addr_reg  <= pend_addr_next;
        run_h_reg      <= run_h_next;
        run_v_reg      <= run_v_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### src/grcc_checker.sv
// Port-level checker for the cover counter, bound to the top level.
`include "assert_macros.svh"

module grcc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_ready,
    input  grcc_pkg::grcc_in_t               req,
    input  logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  grcc_pkg::grcc_out_t              rsp,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [grcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [grcc_pkg::SIZE_W-1:0]      cfg_data
);

    import grcc_pkg::*;

    // A stalled result holds its payload
    `GRCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

    // One item at a time: no item is taken in the cycle after one is taken
    `GRCC_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "item taken while busy")

    // A rejected add carries no counts
    `GRCC_ASSERT(a_reject_zero, !(rsp_valid && rsp.status == STATUS_REJECT) || (rsp.horizontal_count == '0 && rsp.vertical_count == '0), "rejected add with non-zero counts")

    // Size writes are never held off
    `GRCC_ASSERT(a_cfg_ready, !cfg_valid || cfg_ready, "configuration write stalled")

endmodule

bind grid_rectangle_cover_counter_top grcc_checker u_grcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
